// ----- rtl/core/tksmh_pkg.sv -----
// Shared types and constants for the bounded top-k selector.
// Holds payload structs, heap entry type, datapath op codes and FSM states.
// No dependencies.
package tksmh_pkg;

  localparam int KW = 7;
  localparam logic [KW-1:0] KEEP_RESET = 7'd10;

  localparam logic CMD_OFFER  = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] cand_distance;
    logic [30:0] cand_index;
    logic        cand_live;
  } in_item_t;

  typedef struct packed {
    logic [30:0] result_index;
    logic [31:0] result_distance;
    logic        result_last;
    logic        result_empty;
  } out_item_t;

  typedef struct packed {
    logic [31:0] distance;
    logic [30:0] idx;
  } entry_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_APPEND,
    DP_UP_RD,
    DP_UP_CMP,
    DP_ROOT_RD,
    DP_ROOT_CMP,
    DP_DN_RD,
    DP_DN_CMP,
    DP_POP_INIT,
    DP_POP_RD,
    DP_POP_WR,
    DP_EM_RD,
    DP_EM_LD,
    DP_EMPTY_LD
  } dp_op_t;

  typedef struct packed {
    logic finish;
    logic live;
    logic cnt_zero;
    logic can_append;
    logic pos_zero;
    logic up_stop;
    logic lt_root;
    logic dn_leaf;
    logic dn_stop;
    logic sz_le1;
    logic em_last;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_UP_RD,
    S_UP_CMP,
    S_ROOT_RD,
    S_ROOT_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_POP_RD,
    S_POP_WR,
    S_EM_RD,
    S_EM_LD,
    S_EMPTY
  } state_t;

endpackage

// ----- rtl/core/tksmh_dp.sv -----
// Datapath of the top-k selector: heap memory, sift registers, output register.
// Driven by op codes from tksmh_ctrl; depends on tksmh_pkg.
module tksmh_dp #(
  parameter int MAX_KEEP = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [tksmh_pkg::KW-1:0] cfg_data,
  input  tksmh_pkg::in_item_t    in_data,
  input  tksmh_pkg::dp_op_t      op,
  output tksmh_pkg::dp_stat_t    stat,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tksmh_pkg::out_item_t   out_data
);

  localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CW = $clog2(MAX_KEEP + 1);
  localparam int XW = AW + 2;
  localparam int KW = tksmh_pkg::KW;

  tksmh_pkg::entry_t mem [MAX_KEEP];

  logic [KW-1:0]        kc_r;
  tksmh_pkg::in_item_t  in_r;
  tksmh_pkg::entry_t    v_r;
  logic [AW-1:0]        pos_r;
  logic [CW-1:0]        sz_r;
  logic [CW-1:0]        cnt_r;
  logic [AW-1:0]        e_r;
  tksmh_pkg::entry_t    rd_a_r;
  tksmh_pkg::entry_t    rd_b_r;
  logic                 out_valid_r;
  tksmh_pkg::out_item_t out_data_r;

  logic [KW-1:0]     k_eff;
  logic [XW-1:0]     left_x;
  logic [XW-1:0]     right_x;
  logic [XW-1:0]     sz_x;
  logic [AW-1:0]     parent;
  logic [AW-1:0]     last_addr;
  logic              l_ok;
  logic              r_ok;
  logic              big_l;
  logic              big_r;
  tksmh_pkg::entry_t cur;
  logic              rd_en;
  logic [AW-1:0]     ra;
  logic [AW-1:0]     rb;
  logic              we;
  logic [AW-1:0]     wa;
  tksmh_pkg::entry_t wd;
  logic              out_load;
  tksmh_pkg::out_item_t out_nxt;

  always_comb begin
    if (kc_r == '0) begin
      k_eff = KW'(1);
    end else if (kc_r > KW'(MAX_KEEP)) begin
      k_eff = KW'(MAX_KEEP);
    end else begin
      k_eff = kc_r;
    end
  end

  assign left_x    = {1'b0, pos_r, 1'b1};
  assign right_x   = left_x + XW'(1);
  assign sz_x      = XW'(sz_r);
  assign parent    = (pos_r - AW'(1)) >> 1;
  assign last_addr = AW'(sz_r - CW'(1));
  assign l_ok      = left_x < sz_x;
  assign r_ok      = right_x < sz_x;
  assign big_l     = l_ok && (rd_a_r.distance > v_r.distance);
  assign cur       = big_l ? rd_a_r : v_r;
  assign big_r     = r_ok && (rd_b_r.distance > cur.distance);

  assign stat.finish     = in_r.command == tksmh_pkg::CMD_FINISH;
  assign stat.live       = in_r.cand_live;
  assign stat.cnt_zero   = cnt_r == '0;
  assign stat.can_append = (cnt_r < CW'(MAX_KEEP)) && (KW'(cnt_r) < k_eff);
  assign stat.pos_zero   = pos_r == '0;
  assign stat.up_stop    = rd_a_r.distance >= v_r.distance;
  assign stat.lt_root    = v_r.distance < rd_a_r.distance;
  assign stat.dn_leaf    = !l_ok;
  assign stat.dn_stop    = !big_l && !big_r;
  assign stat.sz_le1     = sz_r <= CW'(1);
  assign stat.em_last    = CW'(e_r) == (cnt_r - CW'(1));
  assign stat.out_free   = !out_valid_r || out_ready;

  // Memory port control per op.
  always_comb begin
    rd_en = 1'b0;
    ra    = '0;
    rb    = '0;
    we    = 1'b0;
    wa    = pos_r;
    wd    = v_r;
    case (op)
      tksmh_pkg::DP_UP_RD: begin
        if (pos_r == '0) begin
          we = 1'b1;
        end else begin
          rd_en = 1'b1;
          ra    = parent;
        end
      end
      tksmh_pkg::DP_UP_CMP: begin
        we = 1'b1;
        wd = stat.up_stop ? v_r : rd_a_r;
      end
      tksmh_pkg::DP_ROOT_RD: begin
        rd_en = 1'b1;
      end
      tksmh_pkg::DP_DN_RD: begin
        if (!l_ok) begin
          we = 1'b1;
        end else begin
          rd_en = 1'b1;
          ra    = left_x[AW-1:0];
          rb    = right_x[AW-1:0];
        end
      end
      tksmh_pkg::DP_DN_CMP: begin
        we = 1'b1;
        wd = big_r ? rd_b_r : (big_l ? rd_a_r : v_r);
      end
      tksmh_pkg::DP_POP_RD: begin
        rd_en = 1'b1;
        rb    = last_addr;
      end
      tksmh_pkg::DP_POP_WR: begin
        we = 1'b1;
        wa = last_addr;
        wd = rd_a_r;
      end
      tksmh_pkg::DP_EM_RD: begin
        rd_en = 1'b1;
        ra    = e_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[ra];
      rd_b_r <= mem[rb];
    end
  end

  always_comb begin
    out_load = 1'b0;
    out_nxt  = out_data_r;
    case (op)
      tksmh_pkg::DP_EM_LD: begin
        out_load                = 1'b1;
        out_nxt.result_index    = rd_a_r.idx;
        out_nxt.result_distance = rd_a_r.distance;
        out_nxt.result_last     = stat.em_last;
        out_nxt.result_empty    = 1'b0;
      end
      tksmh_pkg::DP_EMPTY_LD: begin
        out_load                = 1'b1;
        out_nxt.result_index    = '0;
        out_nxt.result_distance = '0;
        out_nxt.result_last     = 1'b1;
        out_nxt.result_empty    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_nxt;
    end
    case (op)
      tksmh_pkg::DP_LATCH: begin
        in_r         <= in_data;
        v_r.distance <= in_data.cand_distance;
        v_r.idx      <= in_data.cand_index;
      end
      tksmh_pkg::DP_APPEND:   pos_r <= AW'(cnt_r);
      tksmh_pkg::DP_UP_CMP: begin
        if (!stat.up_stop) begin
          pos_r <= parent;
        end
      end
      tksmh_pkg::DP_ROOT_CMP: begin
        pos_r <= '0;
        sz_r  <= cnt_r;
      end
      tksmh_pkg::DP_DN_CMP: begin
        if (big_r) begin
          pos_r <= right_x[AW-1:0];
        end else if (big_l) begin
          pos_r <= left_x[AW-1:0];
        end
      end
      tksmh_pkg::DP_POP_INIT: sz_r <= cnt_r;
      tksmh_pkg::DP_POP_WR: begin
        v_r   <= rd_b_r;
        sz_r  <= sz_r - CW'(1);
        pos_r <= '0;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kc_r        <= tksmh_pkg::KEEP_RESET;
      cnt_r       <= '0;
      e_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        kc_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (op)
        tksmh_pkg::DP_LATCH:  e_r <= '0;
        tksmh_pkg::DP_APPEND: cnt_r <= cnt_r + CW'(1);
        tksmh_pkg::DP_EM_LD: begin
          if (stat.em_last) begin
            cnt_r <= '0;
          end else begin
            e_r <= e_r + AW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_KEEP))
    else $error("entry count above heap depth");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> stat.out_free)
    else $error("result loaded over an untaken result");

  a_clear_last: assert property (@(posedge clk) disable iff (!rst_n)
    (op == tksmh_pkg::DP_EM_LD && stat.em_last) |=> cnt_r == '0)
    else $error("heap not cleared after last result");

endmodule

// ----- rtl/core/tksmh_ctrl.sv -----
// Controller state machine for the top-k selector.
// Sequences offers, sifts, heapsort and emission; depends on tksmh_pkg.
module tksmh_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tksmh_pkg::dp_stat_t stat,
  output tksmh_pkg::dp_op_t   op
);

  tksmh_pkg::state_t state_r, state_nxt;
  logic              sort_r, sort_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tksmh_pkg::S_IDLE;
      sort_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sort_r  <= sort_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sort_nxt  = sort_r;
    op        = tksmh_pkg::DP_NOP;
    in_ready  = 1'b0;
    case (state_r)
      tksmh_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op        = tksmh_pkg::DP_LATCH;
          state_nxt = tksmh_pkg::S_DECIDE;
        end
      end
      tksmh_pkg::S_DECIDE: begin
        if (stat.finish) begin
          if (stat.cnt_zero) begin
            state_nxt = tksmh_pkg::S_EMPTY;
          end else begin
            op        = tksmh_pkg::DP_POP_INIT;
            sort_nxt  = 1'b1;
            state_nxt = tksmh_pkg::S_POP_RD;
          end
        end else if (!stat.live) begin
          state_nxt = tksmh_pkg::S_IDLE;
        end else if (stat.can_append) begin
          op        = tksmh_pkg::DP_APPEND;
          state_nxt = tksmh_pkg::S_UP_RD;
        end else begin
          state_nxt = tksmh_pkg::S_ROOT_RD;
        end
      end
      tksmh_pkg::S_UP_RD: begin
        op        = tksmh_pkg::DP_UP_RD;
        state_nxt = stat.pos_zero ? tksmh_pkg::S_IDLE : tksmh_pkg::S_UP_CMP;
      end
      tksmh_pkg::S_UP_CMP: begin
        op        = tksmh_pkg::DP_UP_CMP;
        state_nxt = stat.up_stop ? tksmh_pkg::S_IDLE : tksmh_pkg::S_UP_RD;
      end
      tksmh_pkg::S_ROOT_RD: begin
        op        = tksmh_pkg::DP_ROOT_RD;
        state_nxt = tksmh_pkg::S_ROOT_CMP;
      end
      tksmh_pkg::S_ROOT_CMP: begin
        op        = tksmh_pkg::DP_ROOT_CMP;
        state_nxt = stat.lt_root ? tksmh_pkg::S_DN_RD : tksmh_pkg::S_IDLE;
      end
      tksmh_pkg::S_DN_RD: begin
        op = tksmh_pkg::DP_DN_RD;
        if (!stat.dn_leaf) begin
          state_nxt = tksmh_pkg::S_DN_CMP;
        end else begin
          state_nxt = sort_r ? tksmh_pkg::S_POP_RD : tksmh_pkg::S_IDLE;
        end
      end
      tksmh_pkg::S_DN_CMP: begin
        op = tksmh_pkg::DP_DN_CMP;
        if (!stat.dn_stop) begin
          state_nxt = tksmh_pkg::S_DN_RD;
        end else begin
          state_nxt = sort_r ? tksmh_pkg::S_POP_RD : tksmh_pkg::S_IDLE;
        end
      end
      tksmh_pkg::S_POP_RD: begin
        if (stat.sz_le1) begin
          sort_nxt  = 1'b0;
          state_nxt = tksmh_pkg::S_EM_RD;
        end else begin
          op        = tksmh_pkg::DP_POP_RD;
          state_nxt = tksmh_pkg::S_POP_WR;
        end
      end
      tksmh_pkg::S_POP_WR: begin
        op        = tksmh_pkg::DP_POP_WR;
        state_nxt = tksmh_pkg::S_DN_RD;
      end
      tksmh_pkg::S_EM_RD: begin
        op        = tksmh_pkg::DP_EM_RD;
        state_nxt = tksmh_pkg::S_EM_LD;
      end
      tksmh_pkg::S_EM_LD: begin
        if (stat.out_free) begin
          op        = tksmh_pkg::DP_EM_LD;
          state_nxt = stat.em_last ? tksmh_pkg::S_IDLE : tksmh_pkg::S_EM_RD;
        end
      end
      tksmh_pkg::S_EMPTY: begin
        if (stat.out_free) begin
          op        = tksmh_pkg::DP_EMPTY_LD;
          state_nxt = tksmh_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tksmh_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/top_k_smallest_max_heap.sv -----
// Top-k selector: an offer is skipped, loses to the root, sifts down from the root, or is
// appended and walks up a MAX_KEEP-entry heap. Finish runs one heapsort pop after another, ends
// the sort, then emits each result in turn (a single empty result for an empty finish).
// One item is worked at a time; the output register lets a new item enter while the last
// result still waits. Synchronous active-low reset empties the heap, sets keep_count to 10.
module top_k_smallest_max_heap #(
  parameter int MAX_KEEP = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  tksmh_pkg::in_item_t      in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output tksmh_pkg::out_item_t     out_data,
  input  logic                     cfg_we,
  input  logic [tksmh_pkg::KW-1:0] cfg_data
);

  // Command and status between sequencer and datapath.
  tksmh_pkg::dp_op_t   op;
  tksmh_pkg::dp_stat_t stat;

  // Sequencer: decide offer vs finish, walk sifts one level at a time through a
  // read state and a compare state, run the heapsort that leaves entries ascending
  // in place, then transfer them out from slot 0 upward.
  tksmh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .op       (op)
  );

  // Heap memory, sift registers and the output register.
  tksmh_dp #(
    .MAX_KEEP (MAX_KEEP)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .op        (op),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- bench/top_k_smallest_max_heap_test.sv -----
// Testbench for the bounded top-k selector: offers and finish commands in, sorted kept
// entries out, checked against an in-bench max-heap predictor.
// Depends on tksmh_pkg and top_k_smallest_max_heap.
module top_k_smallest_max_heap_test;

  localparam int MAXK = 64;
  localparam int CYCLE_LIMIT = 2000000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  tksmh_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  tksmh_pkg::out_item_t out_data;
  logic                 cfg_we;
  logic [tksmh_pkg::KW-1:0] cfg_data;

  top_k_smallest_max_heap #(.MAX_KEEP(MAXK)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Predictor state: heap contents, fill level and the keep count register.
  logic [31:0] heap_dist [MAXK];
  logic [30:0] heap_idx [MAXK];
  int          heap_fill;
  logic [tksmh_pkg::KW-1:0] keep_reg;
  tksmh_pkg::out_item_t sorted_results[$];

  int errors = 0;
  int cycles = 0;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Bound the run; a hang ends here as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("top_k_smallest_max_heap_test failed");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("MISMATCH at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic void swap_entries(input int a, input int b);
    logic [31:0] d;
    logic [30:0] i;
    d = heap_dist[a]; i = heap_idx[a];
    heap_dist[a] = heap_dist[b]; heap_idx[a] = heap_idx[b];
    heap_dist[b] = d; heap_idx[b] = i;
  endfunction

  function automatic void sift_up(input int pos);
    int up;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (heap_dist[up] >= heap_dist[pos]) break;
      swap_entries(up, pos);
      pos = up;
    end
  endfunction

  function automatic void heap_lower(input int count, input int pos);
    int l, r, big;
    while (pos < count) begin
      l = 2 * pos + 1;
      r = l + 1;
      big = pos;
      if (l < count && heap_dist[l] > heap_dist[big]) big = l;
      if (r < count && heap_dist[r] > heap_dist[big]) big = r;
      if (big == pos) break;
      swap_entries(big, pos);
      pos = big;
    end
  endfunction

  // Apply one accepted item to the predicted heap; queue any results.
  function automatic void predict_item(input tksmh_pkg::in_item_t it);
    int k, size;
    tksmh_pkg::out_item_t r;
    tksmh_pkg::out_item_t popped[$];
    k = int'(keep_reg);
    if (k < 1) k = 1;
    if (k > MAXK) k = MAXK;
    if (it.command == tksmh_pkg::CMD_OFFER) begin
      if (!it.cand_live) return;
      if (heap_fill < k) begin
        heap_dist[heap_fill] = it.cand_distance;
        heap_idx[heap_fill] = it.cand_index;
        sift_up(heap_fill);
        heap_fill++;
      end else if (heap_fill > 0 && it.cand_distance < heap_dist[0]) begin
        heap_dist[0] = it.cand_distance;
        heap_idx[0] = it.cand_index;
        heap_lower(heap_fill, 0);
      end
      return;
    end
    if (heap_fill == 0) begin
      r = '0;
      r.result_last = 1'b1;
      r.result_empty = 1'b1;
      sorted_results.push_back(r);
      return;
    end
    size = heap_fill;
    for (int n = 0; n < heap_fill; n++) begin
      r = '0;
      r.result_index = heap_idx[0];
      r.result_distance = heap_dist[0];
      r.result_last = (n == 0);
      popped.push_front(r);
      heap_dist[0] = heap_dist[size - 1];
      heap_idx[0] = heap_idx[size - 1];
      size--;
      if (size > 0) heap_lower(size, 0);
    end
    foreach (popped[j]) sorted_results.push_back(popped[j]);
    heap_fill = 0;
  endfunction

  // Receiver: random stall, optional long hold-off, then check each transfer.
  always @(posedge clk) begin
    tksmh_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sorted_results.size() == 0) begin
        report("result with nothing expected");
      end else begin
        want = sorted_results.pop_front();
        if (out_data.result_index !== want.result_index)
          report($sformatf("index got %0d want %0d", out_data.result_index,
                           want.result_index));
        if (out_data.result_distance !== want.result_distance)
          report($sformatf("distance got %h want %h", out_data.result_distance,
                           want.result_distance));
        if (out_data.result_last !== want.result_last)
          report($sformatf("last got %b want %b", out_data.result_last, want.result_last));
        if (out_data.result_empty !== want.result_empty)
          report($sformatf("empty got %b want %b", out_data.result_empty,
                           want.result_empty));
      end
    end
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Send one item: random idle gap, then hold valid until the transfer.
  // Valid stays up after the transfer; the next call or drain() moves it.
  task automatic send_item(input tksmh_pkg::in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(it);
  endtask

  function automatic tksmh_pkg::in_item_t make_offer(input logic [31:0] d,
                                                     input logic [30:0] i,
                                                     input logic live);
    tksmh_pkg::in_item_t it;
    it.command = tksmh_pkg::CMD_OFFER;
    it.cand_distance = d;
    it.cand_index = i;
    it.cand_live = live;
    return it;
  endfunction

  function automatic tksmh_pkg::in_item_t make_finish();
    tksmh_pkg::in_item_t it;
    it.command = tksmh_pkg::CMD_FINISH;
    it.cand_distance = $urandom();
    it.cand_index = 31'($urandom());
    it.cand_live = 1'($urandom_range(1));
    return it;
  endfunction

  // Drop valid, wait for every expected result, then for the block to settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sorted_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_keep(input logic [tksmh_pkg::KW-1:0] k);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= k;
    @(posedge clk);
    cfg_we <= 1'b0;
    keep_reg = k;
  endtask

  function automatic logic [31:0] rand_dist();
    case ($urandom_range(3))
      0: return $urandom_range(7);
      1: return 32'hFFFF_FFF8 | $urandom_range(7);
      default: return $urandom();
    endcase
  endfunction

  // Extremes, skipped offers, empty finish, ties and finish-field noise.
  task automatic test_directed();
    send_item(make_finish());
    send_item(make_offer(32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1));
    send_item(make_offer(32'h0, 31'h0, 1'b1));
    send_item(make_offer(32'h5, 31'h1234, 1'b0));
    send_item(make_offer(32'h8000_0000, 31'h4000_0000, 1'b1));
    send_item(make_offer(32'h8000_0000, 31'h2AAA_AAAA, 1'b1));
    send_item(make_offer(32'h7FFF_FFFF, 31'h5555_5555, 1'b1));
    send_item(make_finish());
    send_item(make_offer(32'h1, 31'h1, 1'b0));
    send_item(make_finish());
    write_keep(7'd1);
    send_item(make_offer(32'h10, 31'h10, 1'b1));
    send_item(make_offer(32'h10, 31'h11, 1'b1));
    send_item(make_offer(32'hF, 31'h12, 1'b1));
    send_item(make_offer(32'h20, 31'h13, 1'b1));
    send_item(make_finish());
  endtask

  // Random runs: mostly live offers, then a finish.
  task automatic test_random(input int items);
    int sent;
    int run_len;
    sent = 0;
    while (sent < items) begin
      run_len = $urandom_range(0, 2 * (keep_reg > MAXK ? MAXK : keep_reg + 1));
      for (int n = 0; n < run_len && sent < items; n++) begin
        send_item(make_offer(rand_dist(), 31'($urandom()), $urandom_range(9) != 0));
        sent++;
      end
      send_item(make_finish());
      sent++;
    end
  endtask

  // Lower k with the heap fuller than the new k: the heap keeps its size.
  task automatic test_k_lowered();
    write_keep(7'd12);
    for (int n = 0; n < 12; n++) send_item(make_offer($urandom(), 31'(n), 1'b1));
    write_keep(7'd3);
    for (int n = 0; n < 6; n++) send_item(make_offer($urandom(), 31'(100 + n), 1'b1));
    send_item(make_finish());
  endtask

  // Hold the receiver off while offers and finishes keep coming.
  task automatic test_backpressure();
    write_keep(7'd64);
    hold_off_cycles = 3000;
    for (int n = 0; n < 64; n++) send_item(make_offer($urandom(), 31'($urandom()), 1'b1));
    send_item(make_finish());
    send_item(make_finish());
    for (int n = 0; n < 4; n++) send_item(make_offer($urandom(), 31'($urandom()), 1'b1));
    send_item(make_finish());
    // Pause the sender until every result is in.
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    heap_fill = 0;
    keep_reg = tksmh_pkg::KEEP_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_k_lowered();
    test_backpressure();

    // Walk through settings and idling phases, extremes included.
    write_keep(7'd0);
    test_random(40);
    write_keep(7'd127);
    test_random(60);
    send_idle_pct = 73;
    write_keep(7'd5);
    test_random(80);
    send_idle_pct = 0;
    recv_stall_pct = 73;
    write_keep(7'd64);
    test_random(80);
    send_idle_pct = 38;
    recv_stall_pct = 38;
    write_keep(7'd2);
    test_random(70);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_keep(7'd10);
    test_random(45);

    drain();
    if (errors == 0) begin
      $display("top_k_smallest_max_heap_test passed");
    end else begin
      $display("top_k_smallest_max_heap_test failed");
    end
    $finish;
  end

endmodule
